// ===== sv/mpd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mouse packet decoder package
// Shared constants and types for the five-byte serial mouse decoder.
// ---------------------------------------------------------------------------
package mpd_pkg;

	localparam logic [7:0] SYNC_MASK  = 8'hF8;
	localparam logic [7:0] SYNC_VALUE = 8'h80;

	// Event kinds carried on tuser.
	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_RELEASE = 2'd1;
	localparam logic [1:0] EV_MOTION  = 2'd2;

	// Byte count positions within a packet.
	localparam logic [2:0] CNT_IDLE  = 3'd0;
	localparam logic [2:0] CNT_BYTE1 = 3'd1;
	localparam logic [2:0] CNT_BYTE2 = 3'd2;
	localparam logic [2:0] CNT_BYTE3 = 3'd3;
	localparam logic [2:0] CNT_BYTE4 = 3'd4;

	// A completed packet, ready for event generation.
	typedef struct packed {
		logic [2:0]        buttons;
		logic signed [8:0] dx;
		logic signed [9:0] dy;
	} pkt_t;

endpackage

// ===== sv/mpd_assembler.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mouse packet assembler
// Hunts for the sync byte, gathers the four motion bytes and presents the
// completed packet, with its summed deltas, while the fifth byte is held.
// ---------------------------------------------------------------------------
module mpd_assembler
	import mpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_vld,
	input  logic [7:0] rx_byte,
	input  logic       take,
	output logic       done,
	output pkt_t       pkt
);

	logic [2:0] count_q;
	logic [2:0] buttons_q;
	logic [7:0] b1_q;
	logic [7:0] b2_q;
	logic [7:0] b3_q;
	logic signed [8:0] sum_y;

	assign done = byte_vld && (count_q == CNT_BYTE4);

	// Bytes one and three give x; bytes two and four give the negated y.
	assign sum_y = $signed({b2_q[7], b2_q}) + $signed({rx_byte[7], rx_byte});
	assign pkt.buttons = buttons_q;
	assign pkt.dx = $signed({b1_q[7], b1_q}) + $signed({b3_q[7], b3_q});
	assign pkt.dy = 10'sd0 - $signed({sum_y[8], sum_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_IDLE;
		end else if (take) begin
			case (count_q)
				CNT_BYTE1: begin
					count_q <= CNT_BYTE2;
				end
				CNT_BYTE2: begin
					count_q <= CNT_BYTE3;
				end
				CNT_BYTE3: begin
					count_q <= CNT_BYTE4;
				end
				CNT_BYTE4: begin
					count_q <= CNT_IDLE;
				end
				default: begin
					if ((rx_byte & SYNC_MASK) == SYNC_VALUE) begin
						count_q <= CNT_BYTE1;
					end else begin
						count_q <= CNT_IDLE;
					end
				end
			endcase
		end
	end

	// Packet bytes carry no reset; they are only read once written.
	always_ff @(posedge clk) begin
		if (take) begin
			case (count_q)
				CNT_BYTE1: begin
					b1_q <= rx_byte;
				end
				CNT_BYTE2: begin
					b2_q <= rx_byte;
				end
				CNT_BYTE3: begin
					b3_q <= rx_byte;
				end
				CNT_BYTE4: begin
				end
				default: begin
					buttons_q <= rx_byte[2:0];
				end
			endcase
		end
	end

endmodule

// ===== sv/mouse_packet_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mouse packet decoder
// Turns the five-byte serial mouse stream into button and motion events.
// ---------------------------------------------------------------------------
// Usage:
// Bytes from the serial receiver arrive one word at a time on the s_ group.
// Until a sync byte of the form 10000xxx is seen, every word is dropped.
// The sync byte and the four motion bytes that follow make up one packet.
// When the fifth byte has been taken, the block emits one press or release
// word for each button that changed since the previous packet (button 1
// first), then one motion word if either delta is nonzero. The final word
// of a packet carries tlast; a packet with no change and no motion gives
// nothing.
// Each input word passes through the input register; the event list is
// loaded on the edge that takes the fifth byte, and its first event is
// offered in the cycle after. Events leave one per cycle while the receiver
// is ready, so a packet produces at most four words. Bytes are accepted
// every cycle, except that input stalls when a fifth byte meets an event
// list that still holds more than the word leaving this cycle.
// After reset the block waits for sync and all three buttons count as
// released. A stalled receiver holds the current event word steady.
// ---------------------------------------------------------------------------
module mouse_packet_decoder
	import mpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [1:0] button_number, [10:2] delta_x,
	                              // [20:11] delta_y, [23:21] zero
	output logic [1:0]  m_tuser,  // [1:0] event_kind
	output logic        m_tlast   // last_event
);

	// Input register.
	logic       in_vld_s1;
	logic [7:0] in_byte_s1;

	// Event list: bit 0 to 2 are buttons 1 to 3, bit 3 is motion.
	logic [3:0]        pend_q;
	logic [2:0]        rel_q;
	logic signed [8:0] dx_q;
	logic signed [9:0] dy_q;
	logic [2:0]        prev_q;

	logic       done;
	pkt_t       pkt;
	logic       take;
	logic       room;
	logic       pop;
	logic       load;
	logic [3:0] pend_rest;
	logic [2:0] chg;
	logic       motion;
	logic [1:0] kind;
	logic [1:0] btn;

	mpd_assembler u_asm (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (in_vld_s1),
		.rx_byte  (in_byte_s1),
		.take     (take),
		.done     (done),
		.pkt      (pkt)
	);

	assign pop       = m_tvalid && m_tready;
	assign pend_rest = pend_q & (pend_q - 4'd1);
	// The list can take a new packet if it is empty or empties this cycle.
	assign room      = (pend_q == 4'd0) || (pend_rest == 4'd0 && pop);
	assign take      = in_vld_s1 && (!done || room);
	assign load      = take && done;
	assign s_tready  = !in_vld_s1 || take;

	assign chg    = pkt.buttons ^ prev_q;
	assign motion = (pkt.dx != 9'sd0) || (pkt.dy != 10'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			in_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
			prev_q <= 3'b111;
		end else if (load) begin
			// Button 1 is sync bit 2, button 3 is sync bit 0.
			pend_q <= {motion, chg[0], chg[1], chg[2]};
			prev_q <= pkt.buttons;
		end else if (pop) begin
			pend_q <= pend_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rel_q <= pkt.buttons;
			dx_q  <= pkt.dx;
			dy_q  <= pkt.dy;
		end
	end

	// Present the lowest pending event.
	always_comb begin
		kind = EV_MOTION;
		btn  = 2'd0;
		if (pend_q[0]) begin
			kind = rel_q[2] ? EV_RELEASE : EV_PRESS;
			btn  = 2'd1;
		end else if (pend_q[1]) begin
			kind = rel_q[1] ? EV_RELEASE : EV_PRESS;
			btn  = 2'd2;
		end else if (pend_q[2]) begin
			kind = rel_q[0] ? EV_RELEASE : EV_PRESS;
			btn  = 2'd3;
		end
	end

	assign m_tvalid = (pend_q != 4'd0);
	assign m_tlast  = (pend_rest == 4'd0);
	assign m_tuser  = kind;
	assign m_tdata  = (kind == EV_MOTION) ? {3'b000, dy_q, dx_q, btn}
	                                      : {3'b000, 10'd0, 9'd0, btn};

endmodule
